// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
	localparam int unsigned RAU_WIDTH = 32;

	typedef enum logic [2:0] {
		FUNC_ADD = 3'd0,
		FUNC_SUB = 3'd1,
		FUNC_MUL = 3'd2,
		FUNC_DIV = 3'd3,
		FUNC_NRM = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_GCD, S_DIVN, S_DIVD,
		S_CHECK, S_OUT
	} state_t;

	// control between sequencer and divider
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

// ===== hw/rtl/rau_if.sv =====
// ----------------------------------------------------------------------------
// rau_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface rau_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact rational add/sub/mul/div/normalize with gcd reduction.
// ----------------------------------------------------------------------------
// One item at a time. An item runs the multiply states S_MUL1, S_MUL2 and
// S_MUL3, then a Euclid gcd where each remainder step runs the shared
// 2*WIDTH-bit restoring divider (data dependent count of steps), then two
// more divider passes to reduce numerator and denominator. Normalize skips
// the multiply states; errors are answered straight from idle, and a zero
// numerator skips the divider.
// The divider is the only long path; in_ch.ready is high only when idle and
// the result register is empty or being taken.
`include "assert_macros.svh"
module rational_arithmetic_unit import rau_pkg::*; #(
	parameter int unsigned WIDTH = RAU_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	rau_if.sink   in_ch,
	rau_if.source out_ch
);
	localparam int unsigned DW = 2 * WIDTH;

	// input payload fields
	logic [2:0]       func;
	logic [WIDTH-1:0] a_num, a_den, b_num;
	logic [WIDTH-2:0] b_den;
	assign func  = in_ch.data.func;
	assign a_num = in_ch.data.a_num;
	assign a_den = in_ch.data.a_den;
	assign b_num = in_ch.data.b_num;
	assign b_den = in_ch.data.b_den;

	state_t state_q, state_d;

	// operand magnitudes and signs
	logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
	logic             sa_q, sb_q;
	logic [2:0]       func_q;
	logic [DW-1:0]    t1_q, t2_q, d_q, n_q;
	logic [DW-1:0]    gx_q, gy_q;
	logic             neg_q;
	// result register
	logic             ovalid_q;
	logic [WIDTH-1:0] rnum_q;
	logic [WIDTH-2:0] rden_q;
	status_t          rst_q;

	// shared multiplier operands
	logic [WIDTH-1:0] mx, my;
	logic [DW-1:0]    prod;
	assign prod = mx * my;

	logic [WIDTH-1:0] m_an, m_ad, m_bn;
	logic             in_sa, in_sad, in_sb;
	assign in_sa  = a_num[WIDTH-1];
	assign in_sad = a_den[WIDTH-1];
	assign in_sb  = b_num[WIDTH-1];
	assign m_an   = in_sa  ? (~a_num + 1'b1) : a_num;
	assign m_ad   = in_sad ? (~a_den + 1'b1) : a_den;
	assign m_bn   = in_sb  ? (~b_num + 1'b1) : b_num;

	logic accept, out_take, bad_in;
	assign in_ch.ready = (state_q == S_IDLE) && (!ovalid_q || out_ch.ready);
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_take    = out_ch.valid && out_ch.ready;
	assign bad_in = (func > FUNC_NRM) || (m_ad == '0) ||
		((func != FUNC_NRM) && (b_den == '0)) ||
		((func == FUNC_DIV) && (b_num == '0));

	// divider
	logic          dv_start;
	logic [DW-1:0] dv_a, dv_b, dv_q, dv_r;
	div_ctl_t      dv_ctl;
	rau_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_a),
		.divisor(dv_b), .ctl(dv_ctl), .quotient(dv_q), .remainder(dv_r)
	);
	logic dv_done;
	assign dv_done = dv_ctl.done;

	// magnitude sum/difference for add and subtract
	logic          s2;
	logic [DW-1:0] comb_n;
	logic          comb_neg;
	always_comb begin
		s2 = (func_q == FUNC_SUB) ? !sb_q : sb_q;
		if (t2_q == '0)
			s2 = 1'b0;
		if (sa_q == s2) begin
			comb_n   = t1_q + t2_q;
			comb_neg = sa_q;
		end else if (t1_q >= t2_q) begin
			comb_n   = t1_q - t2_q;
			comb_neg = sa_q;
		end else begin
			comb_n   = t2_q - t1_q;
			comb_neg = s2;
		end
	end

	logic [DW-1:0] lim;
	logic          ovf;
	assign lim = DW'(1) << (WIDTH - 1);
	assign ovf = (d_q > lim - 1'b1) || (neg_q ? (n_q > lim) : (n_q > lim - 1'b1));

	// multiplier operand selection
	always_comb begin
		mx = an_q;
		my = bd_q;
		unique case (state_q)
			S_MUL1: begin
				if (func_q == FUNC_MUL) begin
					mx = an_q; my = bn_q;
				end else begin
					mx = an_q; my = bd_q;
				end
			end
			S_MUL2: begin
				mx = bn_q; my = ad_q;
			end
			S_MUL3: begin
				mx = ad_q;
				my = (func_q == FUNC_DIV) ? bn_q : bd_q;
			end
			default: begin
				mx = an_q; my = bd_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (accept && !bad_in)
				state_d = (func == FUNC_NRM) ? S_COMB : S_MUL1;
			S_MUL1:  state_d = S_MUL2;
			S_MUL2:  state_d = S_MUL3;
			S_MUL3:  state_d = S_COMB;
			S_COMB:  state_d = S_GCD;
			S_GCD:   if (n_q == '0) state_d = S_OUT;
				else if (gy_q == '0) state_d = S_DIVN;
			S_DIVN:  if (dv_done) state_d = S_DIVD;
			S_DIVD:  if (dv_done) state_d = S_CHECK;
			S_CHECK: state_d = S_OUT;
			S_OUT:   if (!ovalid_q || out_ch.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// divider control
	logic gcd_wait_q, dv_go_q;
	always_comb begin
		dv_start = 1'b0;
		dv_a     = gx_q;
		dv_b     = gy_q;
		unique case (state_q)
			S_GCD: dv_start = (n_q != '0) && (gy_q != '0) && !gcd_wait_q;
			S_DIVN: begin
				dv_start = dv_go_q;
				dv_a = n_q; dv_b = gx_q;
			end
			S_DIVD: begin
				dv_start = dv_go_q;
				dv_a = d_q; dv_b = gx_q;
			end
			default: dv_start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ovalid_q   <= 1'b0;
			gcd_wait_q <= 1'b0;
			dv_go_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_take)
				ovalid_q <= 1'b0;
			if (accept && bad_in)
				ovalid_q <= 1'b1;
			if (state_q == S_OUT && state_d == S_IDLE)
				ovalid_q <= 1'b1;
			if (dv_start)
				gcd_wait_q <= 1'b1;
			else if (dv_done)
				gcd_wait_q <= 1'b0;
			dv_go_q <= (state_q == S_GCD && state_d == S_DIVN) ||
				(state_q == S_DIVN && dv_done);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (accept) begin
				func_q <= func;
				an_q   <= m_an;
				ad_q   <= m_ad;
				bn_q   <= m_bn;
				bd_q   <= WIDTH'(b_den);
				sa_q   <= (in_sa ^ in_sad) && (a_num != '0);
				sb_q   <= in_sb && (b_num != '0);
				t1_q   <= DW'(m_an);
				d_q    <= DW'(m_ad);
				if (bad_in) begin
					rnum_q <= '0;
					rden_q <= (WIDTH-1)'(1);
					rst_q  <= ST_ZERO;
				end
			end
			S_MUL1: t1_q <= prod;
			S_MUL2: t2_q <= prod;
			S_MUL3: d_q <= prod;
			S_COMB: begin
				if (func_q == FUNC_ADD || func_q == FUNC_SUB) begin
					n_q <= comb_n; neg_q <= comb_neg; gx_q <= comb_n;
				end else begin
					n_q <= t1_q; gx_q <= t1_q;
					neg_q <= (func_q == FUNC_NRM) ? sa_q : (sa_q != sb_q);
				end
				gy_q <= d_q;
			end
			S_GCD: if (dv_done) begin
				gx_q <= gy_q;
				gy_q <= dv_r;
			end
			S_DIVN: if (dv_done) n_q <= dv_q;
			S_DIVD: if (dv_done) d_q <= dv_q;
			S_CHECK: begin
				if (ovf) begin
					rnum_q <= '0;
					rden_q <= (WIDTH-1)'(1);
					rst_q  <= ST_OVF;
				end else begin
					rnum_q <= neg_q ? (~n_q[WIDTH-1:0] + 1'b1) : n_q[WIDTH-1:0];
					rden_q <= d_q[WIDTH-2:0];
					rst_q  <= ST_OK;
				end
			end
			S_OUT: if (n_q == '0) begin
				rnum_q <= '0;
				rden_q <= (WIDTH-1)'(1);
				rst_q  <= ST_OK;
			end
			default: ;
		endcase
	end

	assign out_ch.valid       = ovalid_q;
	assign out_ch.data.r_num  = rnum_q;
	assign out_ch.data.r_den  = rden_q;
	assign out_ch.data.status = rst_q;

	`ASSERT_IMPL(a_busy_not_ready, clk, arst_n, state_q != S_IDLE, !in_ch.ready, "ready while busy")
	`ASSERT_IMPL(a_div_idle_start, clk, arst_n, dv_start, !dv_ctl.busy, "divider restarted")
	`ASSERT_NEXT(a_ok_den, clk, arst_n, state_q == S_CHECK && !ovf, rden_q != '0, "zero denominator")
endmodule

// ===== hw/rtl/rau_div.sv =====
// ----------------------------------------------------------------------------
// rau_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div import rau_pkg::*; #(
	parameter int unsigned W = 2 * RAU_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output div_ctl_t     ctl,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  q_q, r_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	assign shifted = {r_q, q_q[W-1]};
	assign trial   = shifted - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= shifted[W-1:0];
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign ctl.start  = start;
	assign ctl.busy   = busy_q;
	assign ctl.done   = done_q;
	assign quotient   = q_q;
	assign remainder  = r_q;
endmodule

// ===== tb/rational_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test
// Drives operation items into the rational unit and checks each result field
// by field against a local exact-arithmetic model or a fixed expectation.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;
	import rau_pkg::*;

	typedef struct packed {
		func_t              func;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} op_item_t;

	typedef struct packed {
		logic signed [31:0] r_num;
		logic [30:0]        r_den;
		status_t            status;
	} res_item_t;

	// directed row: a fixed expectation is used only where it is obvious
	typedef struct {
		op_item_t  op;
		bit        fixed;
		res_item_t want;
	} dir_row_t;

	localparam int NUM_RANDOM  = 400;
	localparam int CALM_TAIL   = 40;     // last items: no idling on either side
	localparam int STALL_LIMIT = 60000;  // cycles without any handshake
	localparam int LONG_HOLD   = 500;    // receiver back-pressure stretch
	localparam int DRAIN_WAIT  = 3200;   // quiet cycles after the last result

	logic clk;
	logic arst_n;

	rau_if #(.payload_t(op_item_t))  in_ch ();
	rau_if #(.payload_t(res_item_t)) out_ch ();

	rational_arithmetic_unit u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch.sink),
		.out_ch(out_ch.source)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	res_item_t pending_q[$];
	dir_row_t  dir_rows[$];
	int        n_fail;
	int        n_sent;
	int        n_checked;
	int        n_err_seen;
	int        n_ovf_seen;
	int        idle_cnt;
	bit        sending_done;
	bit        calm;
	bit        hold_request;

	// Magnitude of a 32-bit two's complement value, widened.
	function automatic logic [63:0] magnitude(logic [31:0] v);
		return v[31] ? (64'h1_0000_0000 - {32'b0, v}) : {32'b0, v};
	endfunction

	// Exact rational result of one operation, reduced, in the unit's format.
	function automatic res_item_t rational_result(op_item_t op);
		res_item_t  r;
		logic [63:0] an, ad, bn, bd, t1, t2, n, d, x, y, t;
		logic       sa, sb, s2, neg;
		an = magnitude(op.a_num);
		ad = magnitude(op.a_den);
		bn = magnitude(op.b_num);
		bd = {33'b0, op.b_den};
		sa = op.a_num[31];
		sb = op.b_num[31];
		r  = '{r_num: '0, r_den: 31'd1, status: ST_ZERO};
		if (op.a_den[31]) sa = !sa;   // A is sign-normalized for every operation
		if (an == 0) sa = 1'b0;
		if (bn == 0) sb = 1'b0;
		if (op.func > FUNC_NRM || ad == 0 || (op.func != FUNC_NRM && bd == 0))
			return r;
		case (op.func)
			FUNC_ADD, FUNC_SUB: begin
				t1 = an * bd;
				t2 = bn * ad;
				s2 = (op.func == FUNC_SUB) ? !sb : sb;
				if (t2 == 0) s2 = 1'b0;
				if (sa == s2) begin
					n = t1 + t2;
					neg = sa;
				end else if (t1 >= t2) begin
					n = t1 - t2;
					neg = sa;
				end else begin
					n = t2 - t1;
					neg = s2;
				end
				d = ad * bd;
			end
			FUNC_MUL: begin
				n = an * bn;
				d = ad * bd;
				neg = sa != sb;
			end
			FUNC_DIV: begin
				if (bn == 0) return r;
				n = an * bd;
				d = ad * bn;
				neg = sa != sb;
			end
			default: begin
				n = an;
				d = ad;
				neg = sa;
			end
		endcase
		r.status = ST_OK;
		if (n == 0) return r;
		x = n;
		y = d;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		n = n / x;
		d = d / x;
		if (d > 64'h7FFF_FFFF || (neg ? (n > 64'h8000_0000) : (n > 64'h7FFF_FFFF))) begin
			r.status = ST_OVF;
			return r;
		end
		t = neg ? (64'd0 - n) : n;
		r.r_num = t[31:0];
		r.r_den = d[30:0];
		return r;
	endfunction

	function automatic op_item_t make_op(func_t f, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [30:0] bd);
		op_item_t op;
		op.func  = f;
		op.a_num = an;
		op.a_den = ad;
		op.b_num = bn;
		op.b_den = bd;
		return op;
	endfunction

	task automatic add_row(op_item_t op, bit fixed, logic [31:0] wn, logic [30:0] wd,
			status_t ws);
		dir_row_t row;
		row.op    = op;
		row.fixed = fixed;
		row.want  = '{r_num: wn, r_den: wd, status: ws};
		dir_rows.push_back(row);
	endtask

	// Numerator-like value: mostly small so results fit, sometimes full width.
	function automatic logic [31:0] rand_signed();
		logic [31:0] v;
		case ($urandom_range(0, 9))
			0:       v = 32'd0;
			1, 2, 3: v = $urandom();
			default: v = $urandom_range(0, 300);
		endcase
		if (v != 0 && $urandom_range(0, 1)) v = -v;
		return v;
	endfunction

	function automatic logic [30:0] rand_den();
		logic [31:0] v;
		case ($urandom_range(0, 29))
			0:          v = 32'd0;
			1, 2, 3, 4: v = $urandom();
			default:    v = $urandom_range(1, 300);
		endcase
		return v[30:0];
	endfunction

	function automatic op_item_t rand_op();
		op_item_t    op;
		logic [31:0] ad;
		int          sel;
		sel = $urandom_range(0, 19);
		op.func  = func_t'(sel < 19 ? sel % 5 : $urandom_range(5, 7));
		op.a_num = rand_signed();
		ad = {1'b0, rand_den()};
		if ($urandom_range(0, 7) == 0) ad = -ad;   // negative A denominator
		if ($urandom_range(0, 40) == 0) ad = $urandom();
		op.a_den = ad;
		op.b_num = rand_signed();
		op.b_den = rand_den();
		return op;
	endfunction

	// Offer one item and hold it until the unit takes it.
	task automatic send_op(op_item_t op, bit fixed, res_item_t want);
		in_ch.valid <= 1'b1;
		in_ch.data  <= op;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_q.push_back(fixed ? want : rational_result(op));
		n_sent++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Stimulus
	initial begin
		res_item_t none;
		none = '{r_num: '0, r_den: 31'd1, status: ST_OK};
		arst_n       <= 1'b0;
		in_ch.valid  <= 1'b0;
		in_ch.data   <= '0;
		calm         = 1'b0;
		sending_done = 1'b0;
		hold_request = 1'b0;

		// extremes, error codes and special cases with obvious answers
		add_row(make_op(FUNC_ADD, 32'd0, 32'd5, 32'd0, 31'd7), 1, 32'd0, 31'd1, ST_OK);
		add_row(make_op(FUNC_DIV, 32'd3, 32'd4, 32'd0, 31'd9), 1, 32'd0, 31'd1, ST_ZERO);
		add_row(make_op(FUNC_ADD, 32'd3, 32'd0, 32'd1, 31'd2), 1, 32'd0, 31'd1, ST_ZERO);
		add_row(make_op(FUNC_MUL, 32'd3, 32'd4, 32'd1, 31'd0), 1, 32'd0, 31'd1, ST_ZERO);
		add_row(make_op(FUNC_NRM, 32'd3, 32'd0, 32'd1, 31'd0), 1, 32'd0, 31'd1, ST_ZERO);
		// normalize ignores a zero B denominator
		add_row(make_op(FUNC_NRM, 32'd6, 32'd4, 32'd1, 31'd0), 1, 32'd3, 31'd2, ST_OK);
		add_row(make_op(FUNC_NRM, -32'sd4, -32'sd6, 32'd0, 31'd1), 1, 32'd2, 31'd3, ST_OK);
		add_row(make_op(func_t'(3'd5), 32'd1, 32'd1, 32'd1, 31'd1), 1, 32'd0, 31'd1, ST_ZERO);
		add_row(make_op(func_t'(3'd6), 32'd1, 32'd1, 32'd1, 31'd1), 1, 32'd0, 31'd1, ST_ZERO);
		add_row(make_op(func_t'(3'd7), 32'd1, 32'd1, 32'd1, 31'd1), 1, 32'd0, 31'd1, ST_ZERO);
		add_row(make_op(FUNC_NRM, 32'h8000_0000, 32'd1, 32'd0, 31'd1), 1,
			32'h8000_0000, 31'd1, ST_OK);
		// flipping the most negative numerator leaves the range
		add_row(make_op(FUNC_NRM, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 31'd1), 1,
			32'd0, 31'd1, ST_OVF);
		add_row(make_op(FUNC_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 31'd1), 1,
			32'd0, 31'd1, ST_OVF);
		add_row(make_op(FUNC_MUL, 32'd1, 32'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFF), 1,
			32'd0, 31'd1, ST_OVF);
		// remaining rows go through the model
		add_row(make_op(FUNC_ADD, 32'd1, 32'd3, 32'd1, 31'd6), 0, '0, 31'd1, ST_OK);
		add_row(make_op(FUNC_SUB, 32'd1, 32'd3, 32'd1, 31'd2), 0, '0, 31'd1, ST_OK);
		add_row(make_op(FUNC_SUB, -32'sd5, -32'sd7, 32'd5, 31'd7), 0, '0, 31'd1, ST_OK);
		add_row(make_op(FUNC_MUL, -32'sd9, 32'd14, 32'd21, 31'd6), 0, '0, 31'd1, ST_OK);
		add_row(make_op(FUNC_DIV, 32'd7, 32'd3, -32'sd14, 31'd9), 0, '0, 31'd1, ST_OK);
		add_row(make_op(FUNC_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000,
			31'h7FFF_FFFF), 0, '0, 31'd1, ST_OK);
		add_row(make_op(FUNC_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			31'h7FFF_FFFF), 0, '0, 31'd1, ST_OK);
		add_row(make_op(FUNC_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			31'h7FFF_FFFF), 0, '0, 31'd1, ST_OK);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_op(dir_rows[i].op, dir_rows[i].fixed, dir_rows[i].want);

		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == NUM_RANDOM / 4) hold_request = 1'b1;
			if (i == NUM_RANDOM - CALM_TAIL) calm = 1'b1;
			send_op(rand_op(), 0, none);
		end
		in_ch.valid <= 1'b0;
		sending_done = 1'b1;
	end

	// Result side back-pressure: random bursts, one long hold, calm tail.
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				// long hold so the unit fills its result slot and stalls its input
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6) - 1) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				if (!calm) repeat ($urandom_range(0, 10)) @(posedge clk);
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result %0d/%0d status %0d", $time,
					$signed(out_ch.data.r_num), out_ch.data.r_den, out_ch.data.status);
				n_fail++;
			end else begin
				want = pending_q.pop_front();
				n_checked++;
				if (want.status == ST_ZERO) n_err_seen++;
				if (want.status == ST_OVF) n_ovf_seen++;
				if (out_ch.data.r_num !== want.r_num) begin
					$display("%0t: r_num expected %0d got %0d", $time,
						$signed(want.r_num), $signed(out_ch.data.r_num));
					n_fail++;
				end
				if (out_ch.data.r_den !== want.r_den) begin
					$display("%0t: r_den expected %0d got %0d", $time,
						want.r_den, out_ch.data.r_den);
					n_fail++;
				end
				if (out_ch.data.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time,
						want.status, out_ch.data.status);
					n_fail++;
				end
			end
		end
	end

	// Watchdog: cycles with no handshake on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// End of run
	initial begin
		n_fail     = 0;
		n_sent     = 0;
		n_checked  = 0;
		n_err_seen = 0;
		n_ovf_seen = 0;
		idle_cnt   = 0;
		wait (sending_done);
		wait (pending_q.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("Sent %0d items, checked %0d results (%0d zero-denominator, %0d overflow).",
			n_sent, n_checked, n_err_seen, n_ovf_seen);
		if (n_fail == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rau_pkg.sv
hw/rtl/rau_if.sv
hw/rtl/rau_div.sv
hw/rtl/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_test.sv
